// File: hw/rtl/dan_pkg.sv
// Package for the detection argmax / suppression block.
// Types and constants shared by the controller, the datapath and the top level.
package dan_pkg;

  localparam int ScoreW = 16;
  localparam int ClassW = 7;
  localparam int CoordW = 14;
  localparam int EdgeW = 11;
  localparam int SizeW = 10;
  localparam int IouW = 11;

  localparam logic [0:0] RegScoreThr = 1'b0;
  localparam logic [0:0] RegOverlapThr = 1'b1;

  typedef struct packed {
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] top;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } rect_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // register the accepted item
    logic iou_reg;   // register intersection and union of the entry read
    logic scan_rd;   // issue read of scan index
    logic scan_chk;  // compare entry against the registered intersection and union
    logic append;    // append or flag overflow
    logic ro_rd;     // issue readout read
    logic ro_load;   // load output register from read data
    logic ro_empty;  // load empty result
    logic ro_last;   // mark loaded result last
  } dan_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic offer;     // accepted item was last with best above threshold
    logic frame_end;
    logic scan_done; // scan index reached count
    logic ro_match;  // read entry belongs to current class
    logic empty;
  } dan_sts_t;

endpackage

// File: hw/rtl/dan_ctrl.sv
// Controller state machine of the detection argmax / suppression block.
// Depends on dan_pkg for the command and status structs.
module dan_ctrl #(
  parameter int MAX_KEPT = 64,
  parameter int MAX_CLASSES = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  dan_pkg::dan_sts_t sts,
  output logic in_ready,
  output logic [$clog2(MAX_KEPT+1)-1:0] idx,
  output logic [dan_pkg::ClassW-1:0] ro_class,
  output dan_pkg::dan_cmd_t cmd
);
  localparam int IdxW = $clog2(MAX_KEPT+1);
  localparam logic [3:0] S_IDLE = 4'd0, S_EVAL = 4'd1, S_SCAN = 4'd2, S_CHK = 4'd3,
                         S_ADD = 4'd4, S_RORD = 4'd5, S_ROCHK = 4'd6, S_ROWAIT = 4'd7,
                         S_CMP = 4'd8;

  logic [3:0] state, state_next;
  logic [IdxW-1:0] idx_next;
  logic [dan_pkg::ClassW-1:0] ro_class_next;
  logic ro_any, ro_any_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      ro_class <= '0;
      ro_any <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      ro_class <= ro_class_next;
      ro_any <= ro_any_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next = idx;
    ro_class_next = ro_class;
    ro_any_next = ro_any;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.take = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        idx_next = '0;
        ro_class_next = '0;
        ro_any_next = 1'b0;
        if (sts.offer) state_next = S_SCAN;
        else if (sts.frame_end) state_next = S_RORD;
        else state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_ADD;
        else begin
          cmd.scan_rd = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.iou_reg = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.scan_chk = 1'b1;
        idx_next = idx + 1'b1;
        state_next = S_SCAN;
      end
      S_ADD: begin
        cmd.append = 1'b1;
        idx_next = '0;
        state_next = sts.frame_end ? S_RORD : S_IDLE;
      end
      S_RORD: begin
        // walk classes, and within each the entries in insertion order
        if (sts.scan_done) begin
          idx_next = '0;
          if (ro_class == dan_pkg::ClassW'(MAX_CLASSES - 1)) begin
            state_next = S_ROWAIT;
          end else begin
            ro_class_next = ro_class + 1'b1;
          end
        end else begin
          cmd.ro_rd = 1'b1;
          state_next = S_ROCHK;
        end
      end
      S_ROCHK: begin
        if (!sts.ro_match) begin
          idx_next = idx + 1'b1;
          state_next = S_RORD;
        end else if (out_free) begin
          cmd.ro_load = 1'b1;
          ro_any_next = 1'b1;
          idx_next = idx + 1'b1;
          state_next = S_RORD;
        end else begin
          cmd.ro_rd = 1'b1; // hold read data for the retry
        end
      end
      S_ROWAIT: begin
        // final result: either mark the held last entry or issue the empty one
        if (out_free) begin
          if (ro_any) cmd.ro_last = 1'b1;
          else cmd.ro_empty = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |=> state == S_EVAL)
    else $error("accept did not start evaluation");
  assert property (@(posedge clk) disable iff (rst) cmd.ro_load |-> sts.ro_match)
    else $error("loaded entry of wrong class");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !cmd.ro_load)
    else $error("readout while idle");
endmodule

// File: hw/rtl/dan_dp.sv
// Datapath: running argmax, box conversion, kept-entry memory, IoU compare, output register.
// Depends on dan_pkg; driven by dan_ctrl.
module dan_dp #(
  parameter int MAX_KEPT = 64,
  parameter int MAX_CLASSES = 128,
  parameter int IMAGE_SIZE = 1024
) (
  input  logic clk,
  input  logic rst,
  input  dan_pkg::dan_cmd_t cmd,
  input  logic [$clog2(MAX_KEPT+1)-1:0] idx,
  input  logic [dan_pkg::ClassW-1:0] ro_class,
  input  logic cfg_we_score,
  input  logic cfg_we_overlap,
  input  logic [15:0] cfg_data,
  input  logic [15:0] class_score,
  input  logic score_last,
  input  logic frame_start,
  input  logic frame_end,
  input  logic [13:0] center_x,
  input  logic [13:0] center_y,
  input  logic [13:0] box_width,
  input  logic [13:0] box_height,
  input  logic out_take,
  output logic out_valid,
  output logic entry_valid,
  output logic [6:0] class_id,
  output logic [15:0] kept_score,
  output logic signed [10:0] rect_left,
  output logic signed [10:0] rect_top,
  output logic [9:0] rect_width,
  output logic [9:0] rect_height,
  output logic table_overflow,
  output logic last,
  output dan_pkg::dan_sts_t sts
);
  localparam int IdxW = $clog2(MAX_KEPT+1);
  localparam int AdrW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int EntW = 2*dan_pkg::EdgeW + 2*dan_pkg::SizeW + dan_pkg::ClassW + dan_pkg::ScoreW;
  localparam int Lo = -(IMAGE_SIZE/2);
  localparam int Hi = IMAGE_SIZE - 1;

  typedef struct packed {
    dan_pkg::rect_t r;
    logic [dan_pkg::ClassW-1:0] cls;
    logic [dan_pkg::ScoreW-1:0] score;
  } ent_t;

  logic [15:0] score_thr;
  logic [10:0] overlap_thr;
  logic [15:0] best_score;
  logic best_valid;
  logic [6:0] best_class, class_counter;
  logic [IdxW-1:0] entry_count;
  logic overflow_flag;
  logic hit;
  logic offer, fend;
  ent_t newe;
  ent_t mem [MAX_KEPT];
  ent_t rd;

  // item evaluation (combinational on accepted payload)
  logic [15:0] b_s;
  logic b_v;
  logic [6:0] b_c, cc;
  logic win;
  logic signed [15:0] nx, ny;
  logic signed [15:0] ex, ey;

  // IoU: intersection and union registered from the entry read, then compared from the registered values
  logic signed [11:0] x1, y1, x2, y2, ar, br, ab, bb;
  logic [10:0] iw, ih;
  logic [20:0] inter, inter_q;
  logic [21:0] uni, uni_q;
  logic same_cls;
  logic [31:0] lhs, rhs;
  logic ovl;

  // readout staging
  ent_t held;
  logic held_ok;
  logic emit;

  function automatic logic signed [dan_pkg::EdgeW-1:0] edge_px(input logic signed [15:0] n);
    logic signed [15:0] q;
    q = (n < 0) ? -((-n) >>> 5) : (n >>> 5);
    if (q < 16'(Lo)) return dan_pkg::EdgeW'(Lo);
    else if (q > 16'(Hi)) return dan_pkg::EdgeW'(Hi);
    else return q[dan_pkg::EdgeW-1:0];
  endfunction

  function automatic logic [dan_pkg::SizeW-1:0] sz_px(input logic [13:0] s);
    return ((s >> 4) > 14'(Hi)) ? dan_pkg::SizeW'(Hi) : s[13:4];
  endfunction

  always_comb begin
    b_s = frame_start ? '0 : best_score;
    b_v = frame_start ? 1'b0 : best_valid;
    b_c = frame_start ? '0 : best_class;
    cc = frame_start ? '0 : class_counter;
    win = !b_v || (class_score > b_s);
    if (win) begin
      b_s = class_score;
      b_c = cc;
    end
    nx = 16'({center_x, 1'b0}) - 16'(box_width);
    ny = 16'({center_y, 1'b0}) - 16'(box_height);
    ex = nx;
    ey = ny;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr <= 16'd16384;
      overlap_thr <= 11'd461;
      best_valid <= 1'b0;
      best_score <= '0;
      best_class <= '0;
      class_counter <= '0;
      entry_count <= '0;
      overflow_flag <= 1'b0;
      offer <= 1'b0;
      fend <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (cfg_we_score) score_thr <= cfg_data;
      if (cfg_we_overlap) overlap_thr <= cfg_data[10:0];
      if (cmd.take) begin
        if (frame_start) begin
          entry_count <= '0;
          overflow_flag <= 1'b0;
        end
        offer <= score_last && (b_s > score_thr);
        fend <= frame_end;
        hit <= 1'b0;
        if (score_last) begin
          best_valid <= 1'b0;
          best_score <= '0;
          best_class <= '0;
          class_counter <= '0;
        end else begin
          best_valid <= 1'b1;
          best_score <= b_s;
          best_class <= b_c;
          class_counter <= (cc < 7'(MAX_CLASSES - 1)) ? cc + 1'b1 : cc;
        end
      end
      if (cmd.scan_chk && ovl) hit <= 1'b1;
      if (cmd.append && !hit) begin
        if (entry_count >= IdxW'(MAX_KEPT)) overflow_flag <= 1'b1;
        else entry_count <= entry_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      newe.r.left <= edge_px(ex);
      newe.r.top <= edge_px(ey);
      newe.r.width <= sz_px(box_width);
      newe.r.height <= sz_px(box_height);
      newe.cls <= b_c;
      newe.score <= b_s;
    end
  end

  always_comb begin
    x1 = (rd.r.left > newe.r.left) ? 12'(rd.r.left) : 12'(newe.r.left);
    y1 = (rd.r.top > newe.r.top) ? 12'(rd.r.top) : 12'(newe.r.top);
    ar = 12'(rd.r.left) + $signed({2'b0, rd.r.width});
    br = 12'(newe.r.left) + $signed({2'b0, newe.r.width});
    ab = 12'(rd.r.top) + $signed({2'b0, rd.r.height});
    bb = 12'(newe.r.top) + $signed({2'b0, newe.r.height});
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
    iw = (x2 > x1) ? 11'(x2 - x1) : '0;
    ih = (y2 > y1) ? 11'(y2 - y1) : '0;
    inter = 21'(iw * ih);
    uni = 22'(rd.r.width * rd.r.height) + 22'(newe.r.width * newe.r.height) - 22'(inter);
  end

  always_ff @(posedge clk) begin
    if (cmd.iou_reg) begin
      inter_q <= inter;
      uni_q <= uni;
      same_cls <= (rd.cls == newe.cls);
    end
  end

  always_comb begin
    lhs = {1'b0, inter_q, 10'b0};
    rhs = 32'(overlap_thr * uni_q);
    ovl = same_cls && (lhs > rhs);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.ro_rd) rd <= mem[idx[AdrW-1:0]];
    if (cmd.scan_chk && ovl && (rd.score < newe.score)) mem[idx[AdrW-1:0]] <= newe;
    else if (cmd.append && !hit && entry_count < IdxW'(MAX_KEPT))
      mem[entry_count[AdrW-1:0]] <= newe;
  end

  // the last real entry is held back until the next one proves it is not last
  assign emit = cmd.ro_load && held_ok;

  always_ff @(posedge clk) begin
    if (rst) held_ok <= 1'b0;
    else if (cmd.take) held_ok <= 1'b0;
    else if (cmd.ro_load) held_ok <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ro_load) held <= rd;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last <= 1'b0;
    end else begin
      if (emit || cmd.ro_empty || cmd.ro_last) begin
        out_valid <= 1'b1;
        last <= !emit;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit || cmd.ro_empty || cmd.ro_last) table_overflow <= overflow_flag;
    if (cmd.ro_empty) begin
      entry_valid <= 1'b0;
      class_id <= '0;
      kept_score <= '0;
      rect_left <= '0;
      rect_top <= '0;
      rect_width <= '0;
      rect_height <= '0;
    end else if (emit || cmd.ro_last) begin
      entry_valid <= 1'b1;
      class_id <= held.cls;
      kept_score <= held.score;
      rect_left <= held.r.left;
      rect_top <= held.r.top;
      rect_width <= held.r.width;
      rect_height <= held.r.height;
    end
  end

  assign sts.offer = offer;
  assign sts.frame_end = fend;
  assign sts.scan_done = (idx >= entry_count);
  assign sts.ro_match = (rd.cls == ro_class);
  assign sts.empty = (entry_count == '0);

  assert property (@(posedge clk) disable iff (rst) entry_count <= IdxW'(MAX_KEPT))
    else $error("entry count beyond table");
  assert property (@(posedge clk) disable iff (rst)
    cmd.append && !hit && entry_count == IdxW'(MAX_KEPT) |=> overflow_flag)
    else $error("overflow not flagged");
  assert property (@(posedge clk) disable iff (rst) cmd.ro_empty |-> sts.empty)
    else $error("empty result with entries kept");
endmodule

// File: hw/rtl/detection_argmax_nms_top.sv
// Top level of the streaming argmax / per-class suppression block.
// Depends on dan_pkg, dan_ctrl and dan_dp.
//
//  channel | handshake         | payload
//  in      | in_valid/in_ready | class_score .. box_height
//  out     | out_valid/out_ready | entry_valid .. last
//  cfg     | cfg_we            | cfg_index, cfg_data
//
// Each score item is accepted and then evaluated; a last score that is offered then scans each kept entry
// (read, intersection and union, compare) through the single memory port, then appends.
// Readout walks every class up to MAX_CLASSES and reads each kept entry once per class.
// Reset clears the best, counters and flags; table contents need no clearing.
// A stalled output holds the readout; input is taken only between items.
module detection_argmax_nms_top #(
  parameter int MAX_KEPT = 64,
  parameter int MAX_CLASSES = 128,
  parameter int IMAGE_SIZE = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] class_score,
  input  logic score_last,
  input  logic frame_start,
  input  logic frame_end,
  input  logic [13:0] center_x,
  input  logic [13:0] center_y,
  input  logic [13:0] box_width,
  input  logic [13:0] box_height,
  output logic out_valid,
  input  logic out_ready,
  output logic entry_valid,
  output logic [6:0] class_id,
  output logic [15:0] kept_score,
  output logic signed [10:0] rect_left,
  output logic signed [10:0] rect_top,
  output logic [9:0] rect_width,
  output logic [9:0] rect_height,
  output logic table_overflow,
  output logic last,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data
);
  dan_pkg::dan_cmd_t cmd;
  dan_pkg::dan_sts_t sts;
  logic [$clog2(MAX_KEPT+1)-1:0] idx;
  logic [6:0] ro_class;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  dan_ctrl #(.MAX_KEPT(MAX_KEPT), .MAX_CLASSES(MAX_CLASSES)) u_ctrl (
    .clk, .rst, .in_fire(in_valid && in_ready), .out_free, .sts,
    .in_ready, .idx, .ro_class, .cmd
  );

  dan_dp #(.MAX_KEPT(MAX_KEPT), .MAX_CLASSES(MAX_CLASSES), .IMAGE_SIZE(IMAGE_SIZE)) u_dp (
    .clk, .rst, .cmd, .idx, .ro_class,
    .cfg_we_score(cfg_we && cfg_index == dan_pkg::RegScoreThr),
    .cfg_we_overlap(cfg_we && cfg_index == dan_pkg::RegOverlapThr),
    .cfg_data, .class_score, .score_last, .frame_start, .frame_end,
    .center_x, .center_y, .box_width, .box_height,
    .out_take(out_valid && out_ready), .out_valid, .entry_valid, .class_id, .kept_score,
    .rect_left, .rect_top, .rect_width, .rect_height, .table_overflow, .last, .sts
  );
endmodule
